// ----- rtl/dlsw_pkg.sv -----
package dlsw_pkg;

  localparam int unsigned MAX_DIGITS = 6;
  localparam int unsigned LCD_BYTES  = 20;
  localparam int unsigned ROW_COUNT  = 4;
  localparam int unsigned LAST_POS   = 5;

  localparam logic [7:0]  KEEP_ROW0 = 8'h66;
  localparam logic [7:0]  MASK_EVEN = 8'h0f;
  localparam logic [7:0]  MASK_ODD  = 8'hf0;
  // ceil(2^35 / 10): exact quotient by ten for any 32-bit value
  localparam logic [31:0] RECIP_TEN = 32'hcccccccd;
  localparam int unsigned RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPLIT,
    ST_ROWS
  } state_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       split;
    logic       write;
    logic [1:0] row;
    logic [2:0] pos;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic num_pos;
    logic v_zero;
    logic out_free;
  } sts_t;

  function automatic logic [15:0] seg_code(input logic [3:0] digit);
    logic [15:0] code;
    case (digit)
      4'd0:    code = 16'h1551;
      4'd1:    code = 16'h2080;
      4'd2:    code = 16'h1e11;
      4'd3:    code = 16'h1b11;
      4'd4:    code = 16'h0b50;
      4'd5:    code = 16'h1b41;
      4'd6:    code = 16'h1f41;
      4'd7:    code = 16'h0111;
      4'd8:    code = 16'h1f51;
      4'd9:    code = 16'h1b51;
      default: code = 16'h0000;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/dlsw_ctrl.sv -----
module dlsw_ctrl #(
  parameter int unsigned DIGIT_COUNT = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dlsw_pkg::sts_t sts,
  output dlsw_pkg::cmd_t cmd
);

  dlsw_pkg::state_t state_r, state_nxt;
  logic [2:0]       j_r, j_nxt;
  logic [1:0]       row_r, row_nxt;
  logic             final_digit;

  assign final_digit = sts.v_zero || (j_r == 3'(DIGIT_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dlsw_pkg::ST_IDLE;
      j_r     <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      row_r   <= row_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    row_nxt   = row_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.row   = row_r;
    cmd.pos   = 3'(dlsw_pkg::LAST_POS) - j_r;
    cmd.last  = (row_r == 2'(dlsw_pkg::ROW_COUNT - 1)) && final_digit;
    case (state_r)
      dlsw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          j_nxt    = '0;
          if (sts.num_pos) begin
            state_nxt = dlsw_pkg::ST_MUL;
          end
        end
      end
      dlsw_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = dlsw_pkg::ST_SPLIT;
      end
      dlsw_pkg::ST_SPLIT: begin
        cmd.split = 1'b1;
        row_nxt   = '0;
        state_nxt = dlsw_pkg::ST_ROWS;
      end
      dlsw_pkg::ST_ROWS: begin
        if (sts.out_free) begin
          cmd.write = 1'b1;
          if (row_r == 2'(dlsw_pkg::ROW_COUNT - 1)) begin
            if (final_digit) begin
              state_nxt = dlsw_pkg::ST_IDLE;
            end else begin
              j_nxt     = j_r + 3'd1;
              state_nxt = dlsw_pkg::ST_MUL;
            end
          end else begin
            row_nxt = row_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = dlsw_pkg::ST_IDLE;
      end
    endcase
  end

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write && cmd.last |=> state_r == dlsw_pkg::ST_IDLE)
    else $error("last write did not end the item");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dlsw_pkg::ST_ROWS |-> j_r < 3'(DIGIT_COUNT))
    else $error("digit counter past limit");

endmodule

// ----- rtl/dlsw_dp.sv -----
module dlsw_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [31:0] in_number,
  input  logic               out_ready,
  output logic               out_valid,
  output logic        [4:0]  out_reg_index,
  output logic        [7:0]  out_reg_data,
  output logic               out_last,
  input  dlsw_pkg::cmd_t     cmd,
  output dlsw_pkg::sts_t     sts
);

  logic [30:0] v_r, v_nxt;
  logic [62:0] prod_r;
  logic [3:0]  digit_r, digit_nxt;
  logic [7:0]  shadow_r [dlsw_pkg::LCD_BYTES];
  logic        out_valid_r;
  logic [4:0]  out_index_r;
  logic [7:0]  out_data_r;
  logic        out_last_r;

  logic [27:0] quot;
  logic [30:0] quot_ten;
  logic [30:0] rem_full;
  logic [15:0] code;
  logic [3:0]  nib;
  logic [7:0]  mask;
  logic [4:0]  idx;
  logic [7:0]  old_b;
  logic [7:0]  new_b;

  assign quot     = prod_r[62:dlsw_pkg::RECIP_SHIFT];
  assign quot_ten = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_full = v_r - quot_ten;

  always_comb begin
    v_nxt     = v_r;
    digit_nxt = digit_r;
    if (cmd.load) begin
      v_nxt = in_number[30:0];
    end else if (cmd.split) begin
      v_nxt     = {3'b000, quot};
      digit_nxt = rem_full[3:0];
    end
  end

  assign code  = dlsw_pkg::seg_code(digit_r);
  assign nib   = 4'(code >> {cmd.row, 2'b00});
  assign mask  = cmd.pos[0] ? dlsw_pkg::MASK_ODD : dlsw_pkg::MASK_EVEN;
  assign idx   = {3'b000, cmd.pos[2:1]} + {1'b0, cmd.row, 2'b00} + {3'b000, cmd.row};
  assign old_b = shadow_r[idx];

  always_comb begin
    new_b = old_b & ~mask;
    if (cmd.row == 2'd0) begin
      new_b = new_b | (old_b & dlsw_pkg::KEEP_ROW0);
    end
    new_b = new_b | ({nib, nib} & mask);
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    digit_r <= digit_nxt;
    if (cmd.mul) begin
      prod_r <= 63'(v_r) * 63'(dlsw_pkg::RECIP_TEN);
    end
    if (cmd.write) begin
      out_index_r <= idx;
      out_data_r  <= new_b;
      out_last_r  <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < dlsw_pkg::LCD_BYTES; i++) begin
        shadow_r[i] <= '0;
      end
    end else begin
      if (cmd.write) begin
        out_valid_r   <= 1'b1;
        shadow_r[idx] <= new_b;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.num_pos  = !in_number[31] && (in_number != 32'sd0);
  assign sts.v_zero   = (v_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_reg_index = out_index_r;
  assign out_reg_data  = out_data_r;
  assign out_last      = out_last_r;

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.split |=> digit_r < 4'd10)
    else $error("digit out of range");

  a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.split |=> ({4'b0000, v_r} * 35'd10 + {31'b0, digit_r}) == {4'b0000, $past(v_r)})
    else $error("divide by ten mismatch");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_index_r < 5'(dlsw_pkg::LCD_BYTES))
    else $error("register index out of range");

endmodule

// ----- rtl/decimal_lcd_segment_writer.sv -----
// Shows the lowest DIGIT_COUNT decimal digits of a positive number right-aligned on a
// 20-byte segment LCD, keeping a shadow copy of the data bytes. Each digit updates four
// bytes (one per segment row) and each update leaves as one register write on the out_
// channel, with out_last on the final write of the number; zero and negative numbers
// produce no writes. Per digit, the controller steps through the reciprocal multiply by
// 1/10, the split of quotient and digit, and four shadow read-modify-writes, which share
// a single write port and the one-entry output register and wait while the output is
// stalled. A new number is taken only after the last write of the previous one has been
// issued.
module decimal_lcd_segment_writer #(
  parameter int unsigned DIGIT_COUNT = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [4:0]  out_reg_index,
  output logic        [7:0]  out_reg_data,
  output logic               out_last
);

  dlsw_pkg::cmd_t cmd;
  dlsw_pkg::sts_t sts;

  dlsw_ctrl #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dlsw_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_number     (in_number),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_reg_index (out_reg_index),
    .out_reg_data  (out_reg_data),
    .out_last      (out_last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// ----- tb/tb_decimal_lcd_segment_writer.sv -----
module tb_decimal_lcd_segment_writer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int RANDOM_PER_PHASE = 70;
  localparam int HOLD_CYCLES      = 400;
  localparam int TAIL_CYCLES      = 40;
  localparam int DIRECTED_ROWS    = 20;

  typedef struct packed {
    logic [4:0] reg_index;
    logic [7:0] reg_data;
    logic       last;
  } lcd_write_t;

  // typed = 1: expected writes are w0..w(n_typed-1) instead of the predictor's
  typedef struct packed {
    logic [31:0] number;
    logic        typed;
    logic [2:0]  n_typed;
    lcd_write_t  w0;
    lcd_write_t  w1;
    lcd_write_t  w2;
    lcd_write_t  w3;
  } dir_row_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [31:0] in_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_reg_index;
  logic [7:0]  out_reg_data;
  logic        out_last;

  logic [15:0] digit_glyph [10] = '{16'h1551, 16'h2080, 16'h1e11, 16'h1b11, 16'h0b50,
                                    16'h1b41, 16'h1f41, 16'h0111, 16'h1f51, 16'h1b51};
  logic [7:0]  lcd_image [dlsw_pkg::LCD_BYTES];
  lcd_write_t  step_writes [$];
  lcd_write_t  pending_writes [$];

  int mismatch_count = 0;
  int snd_idle_pct   = 11;
  int rcv_idle_pct   = 55;
  int hold_req       = 0;

  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{32'd1, 1'b1, 3'd4, '{5'd2, 8'h00, 1'b0}, '{5'd7, 8'h80, 1'b0},
      '{5'd12, 8'h00, 1'b0}, '{5'd17, 8'h20, 1'b1}},
    '{32'd0,          1'b1, 3'd0, '0, '0, '0, '0},
    '{32'hffff_ffff,  1'b1, 3'd0, '0, '0, '0, '0},
    '{32'h8000_0000,  1'b1, 3'd0, '0, '0, '0, '0},
    '{32'h7fff_ffff,  1'b0, 3'd0, '0, '0, '0, '0},
    '{32'd999999,     1'b0, 3'd0, '0, '0, '0, '0},
    '{32'd1000000,    1'b0, 3'd0, '0, '0, '0, '0},
    '{32'd123456,     1'b0, 3'd0, '0, '0, '0, '0},
    '{32'd123456,     1'b0, 3'd0, '0, '0, '0, '0},
    '{32'd7890,       1'b0, 3'd0, '0, '0, '0, '0},
    '{32'd1234567890, 1'b0, 3'd0, '0, '0, '0, '0},
    '{32'd5,          1'b0, 3'd0, '0, '0, '0, '0},
    '{32'd10,         1'b0, 3'd0, '0, '0, '0, '0},
    '{32'd100001,     1'b0, 3'd0, '0, '0, '0, '0},
    '{32'hfffe_1dc0,  1'b1, 3'd0, '0, '0, '0, '0},
    '{32'd2,          1'b0, 3'd0, '0, '0, '0, '0},
    '{32'd33,         1'b0, 3'd0, '0, '0, '0, '0},
    '{32'd444444,     1'b0, 3'd0, '0, '0, '0, '0},
    '{32'd666,        1'b0, 3'd0, '0, '0, '0, '0},
    '{32'd88888888,   1'b0, 3'd0, '0, '0, '0, '0}
  };

  decimal_lcd_segment_writer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_reg_index (out_reg_index),
    .out_reg_data  (out_reg_data),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Updates the LCD image for one number and lists the byte writes it causes.
  function automatic void predict_lcd_writes(input logic [31:0] value);
    logic [31:0] rest;
    logic [3:0]  digit;
    logic [2:0]  pos;
    logic [7:0]  mask;
    logic [7:0]  b;
    logic [3:0]  nib;
    logic [4:0]  idx;
    lcd_write_t  w;
    step_writes.delete();
    if (value == 32'd0 || value[31]) return;
    rest = value;
    for (int j = 0; j < int'(dlsw_pkg::MAX_DIGITS) && rest != 32'd0; j++) begin
      digit = 4'(rest % 10);
      pos   = 3'(int'(dlsw_pkg::LAST_POS) - j);
      mask  = pos[0] ? dlsw_pkg::MASK_ODD : dlsw_pkg::MASK_EVEN;
      for (int r = 0; r < int'(dlsw_pkg::ROW_COUNT); r++) begin
        idx = 5'(pos >> 1) + 5'(5 * r);
        nib = digit_glyph[digit][4*r +: 4];
        b   = lcd_image[idx];
        if (r == 0) b = (b & ~mask) | (b & dlsw_pkg::KEEP_ROW0);
        else        b = b & ~mask;
        b = b | ({nib, nib} & mask);
        lcd_image[idx] = b;
        step_writes.push_back('{idx, b, 1'b0});
      end
      rest = rest / 10;
    end
    w = step_writes.pop_back();
    w.last = 1'b1;
    step_writes.push_back(w);
  endfunction

  function automatic logic [31:0] random_number();
    int unsigned pick;
    int unsigned ndig;
    int unsigned top;
    pick = $urandom_range(99);
    if (pick < 8) return $urandom() | 32'h8000_0000;
    if (pick < 10) return 32'd0;
    if (pick < 25) return $urandom() & 32'h7fff_ffff;
    ndig = $urandom_range(6, 1);
    top = 1;
    repeat (ndig) top = top * 10;
    return $urandom_range(top - 1, 1);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_row(input dir_row_t row);
    lcd_write_t typed_w [4];
    typed_w = '{row.w0, row.w1, row.w2, row.w3};
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= row.number;
    do @(posedge clk); while (!in_ready);
    predict_lcd_writes(row.number);
    if (row.typed) begin
      for (int k = 0; k < int'(row.n_typed); k++) pending_writes.push_back(typed_w[k]);
    end else begin
      foreach (step_writes[k]) pending_writes.push_back(step_writes[k]);
    end
  endtask

  task automatic wait_all_written();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
  endtask

  // result side: check each transfer, then pick ready for the next cycle
  initial begin
    int         hold_left;
    lcd_write_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_writes.size() == 0) begin
          report_mismatch("write with nothing pending, index", out_reg_index, 0);
        end else begin
          want = pending_writes.pop_front();
          if (out_reg_index !== want.reg_index)
            report_mismatch("reg_index", out_reg_index, want.reg_index);
          if (out_reg_data !== want.reg_data)
            report_mismatch("reg_data", out_reg_data, want.reg_data);
          if (out_last !== want.last)
            report_mismatch("last", out_last, want.last);
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_decimal_lcd_segment_writer: FAIL");
    $finish;
  end

  initial begin
    dir_row_t rand_row;
    foreach (lcd_image[i]) lcd_image[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_row(directed_rows[i]);
    wait_all_written();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 11;
          rcv_idle_pct = 55;
        end
        1: begin
          snd_idle_pct = 55;
          rcv_idle_pct = 11;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        rand_row        = '0;
        rand_row.number = random_number();
        send_row(rand_row);
        // long output stall while inputs keep coming, then a full drain
        if (ph == 0 && i == 20) hold_req = HOLD_CYCLES;
        if (ph == 0 && i == 30) wait_all_written();
      end
      wait_all_written();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_writes.size() != 0)
      report_mismatch("writes never seen, count", pending_writes.size(), 0);

    if (mismatch_count == 0) begin
      $display("tb_decimal_lcd_segment_writer: PASS");
    end else begin
      $display("tb_decimal_lcd_segment_writer: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dlsw_pkg.sv
rtl/dlsw_ctrl.sv
rtl/dlsw_dp.sv
rtl/decimal_lcd_segment_writer.sv
tb/tb_decimal_lcd_segment_writer.sv
